[rtl/core/u2c_pkg.sv]
// Shared types, constants and the lead-byte decode function of the UTF-8 decoder.
package u2c_pkg;

   localparam int CP_WIDTH        = 21;
   localparam int BYTE_WIDTH      = 8;
   localparam int LEN_WIDTH       = 3;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = QUEUE_PTR_WIDTH + 1;

   localparam logic [CP_WIDTH-1:0] REPLACEMENT_CP  = 21'h00FFFD;
   localparam logic [CP_WIDTH-1:0] MAX_CP          = 21'h10FFFF;
   localparam logic [CP_WIDTH-1:0] SURROGATE_FIRST = 21'h00D800;
   localparam logic [CP_WIDTH-1:0] SURROGATE_LAST  = 21'h00DFFF;
   localparam logic [CP_WIDTH-1:0] F4_LEAD_BITS    = 21'h000004;
   localparam logic [CP_WIDTH-1:0] ZERO_BITS       = 21'h000000;

   localparam logic [BYTE_WIDTH-1:0] ASCII_LAST      = 8'h7F;
   localparam logic [BYTE_WIDTH-1:0] NEVER_VALID_LOW = 8'hF5;
   localparam logic [BYTE_WIDTH-1:0] NEVER_VALID_C1  = 8'hC1;
   localparam logic [BYTE_WIDTH-1:0] LEAD_FOUR_FIRST = 8'hF0;
   localparam logic [BYTE_WIDTH-1:0] LEAD_THREE_FIRST = 8'hE0;
   localparam logic [BYTE_WIDTH-1:0] LEAD_TWO_FIRST  = 8'hC0;
   localparam logic [BYTE_WIDTH-1:0] E0_CONT_MIN     = 8'hA0;
   localparam logic [BYTE_WIDTH-1:0] F0_CONT_MIN     = 8'h90;
   localparam logic [BYTE_WIDTH-1:0] C0_CONT_ONLY    = 8'h80;
   localparam logic [1:0]            CONT_TAG        = 2'b10;

   localparam logic [LEN_WIDTH-1:0] LEN_NONE  = 3'd0;
   localparam logic [LEN_WIDTH-1:0] LEN_ONE   = 3'd1;
   localparam logic [LEN_WIDTH-1:0] LEN_TWO   = 3'd2;
   localparam logic [LEN_WIDTH-1:0] LEN_THREE = 3'd3;
   localparam logic [LEN_WIDTH-1:0] LEN_FOUR  = 3'd4;

   typedef struct packed {
      logic                emit;
      logic [CP_WIDTH-1:0] code_point;
      logic                replaced;
      logic                start;
      logic [LEN_WIDTH-1:0] len;
      logic [CP_WIDTH-1:0] bits;
   } lead_type;

   // One queue entry carries all results of one byte: one or two of them.
   typedef struct packed {
      logic                two;
      logic [CP_WIDTH-1:0] cp0;
      logic                rep0;
      logic [CP_WIDTH-1:0] cp1;
      logic                rep1;
   } entry_type;

   function automatic lead_type decode_lead(input logic [BYTE_WIDTH-1:0] c);
      lead_type d;
      d = '0;
      if (c <= ASCII_LAST) begin
         d.emit       = 1'b1;
         d.code_point = {{(CP_WIDTH-BYTE_WIDTH){1'b0}}, c};
      end else if (c >= NEVER_VALID_LOW || c == NEVER_VALID_C1) begin
         d.emit       = 1'b1;
         d.code_point = REPLACEMENT_CP;
         d.replaced   = 1'b1;
      end else if (c >= LEAD_FOUR_FIRST) begin
         d.start = 1'b1;
         d.len   = LEN_FOUR;
         d.bits  = {{(CP_WIDTH-3){1'b0}}, c[2:0]};
      end else if (c >= LEAD_THREE_FIRST) begin
         d.start = 1'b1;
         d.len   = LEN_THREE;
         d.bits  = {{(CP_WIDTH-4){1'b0}}, c[3:0]};
      end else if (c >= LEAD_TWO_FIRST) begin
         d.start = 1'b1;
         d.len   = LEN_TWO;
         d.bits  = {{(CP_WIDTH-5){1'b0}}, c[4:0]};
      end else begin
         d.emit       = 1'b1;
         d.code_point = REPLACEMENT_CP;
         d.replaced   = 1'b1;
      end
      return d;
   endfunction

endpackage

[rtl/core/u2c_front.sv]
// Front end: sequence state, byte classification and result generation per byte.
module u2c_front
   import u2c_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [BYTE_WIDTH-1:0] text_byte,
   input  logic                  final_byte,
   output logic                  q_push,
   output entry_type             q_entry
);

   logic [LEN_WIDTH-1:0] expected_ff, expected_in;
   logic [LEN_WIDTH-1:0] seen_ff, seen_in;
   logic [CP_WIDTH-1:0]  acc_ff, acc_in;

   lead_type             lead;
   logic                 busy;
   logic                 is_cont;
   logic                 fails;
   logic [CP_WIDTH-1:0]  next_acc;
   logic [LEN_WIDTH-1:0] seen_inc;
   logic                 complete;
   logic                 surrogate;
   logic                 a_v, a_rep, b_v, b_rep, c_v;
   logic [CP_WIDTH-1:0]  a_cp, b_cp;
   logic                 r0_v, r1_v;
   logic [LEN_WIDTH-1:0] st_expected, st_seen;
   logic [CP_WIDTH-1:0]  st_acc;

   assign lead      = decode_lead(text_byte);
   assign busy      = (expected_ff != LEN_NONE) && (seen_ff < expected_ff);
   assign is_cont   = (text_byte[7:6] == CONT_TAG);
   assign next_acc  = {acc_ff[CP_WIDTH-7:0], text_byte[5:0]};
   assign seen_inc  = seen_ff + LEN_ONE;
   assign complete  = (seen_inc == expected_ff);
   assign surrogate = (expected_ff == LEN_THREE) && (next_acc >= SURROGATE_FIRST)
                      && (next_acc <= SURROGATE_LAST);

   always_comb begin
      fails = 1'b0;
      if (seen_ff == LEN_ONE) begin
         if (expected_ff == LEN_FOUR && acc_ff == F4_LEAD_BITS && text_byte >= F0_CONT_MIN)
            fails = 1'b1;
         if (acc_ff == ZERO_BITS) begin
            if ((expected_ff == LEN_THREE && text_byte < E0_CONT_MIN) ||
                (expected_ff == LEN_FOUR && text_byte < F0_CONT_MIN) ||
                (expected_ff == LEN_TWO && text_byte != C0_CONT_ONLY))
               fails = 1'b1;
         end
      end
   end

   always_comb begin
      a_v   = 1'b0;
      a_cp  = REPLACEMENT_CP;
      a_rep = 1'b1;
      b_v   = 1'b0;
      b_cp  = lead.code_point;
      b_rep = lead.replaced;
      st_expected = LEN_NONE;
      st_seen     = LEN_NONE;
      st_acc      = ZERO_BITS;
      priority if (!busy) begin
         a_v   = lead.emit;
         a_cp  = lead.code_point;
         a_rep = lead.replaced;
         if (lead.start) begin
            st_expected = lead.len;
            st_seen     = LEN_ONE;
            st_acc      = lead.bits;
         end
      end else if (is_cont && !fails) begin
         if (complete) begin
            a_v   = 1'b1;
            a_cp  = surrogate ? REPLACEMENT_CP : next_acc;
            a_rep = surrogate;
         end else begin
            st_expected = expected_ff;
            st_seen     = seen_inc;
            st_acc      = next_acc;
         end
      end else begin
         a_v = 1'b1;
         b_v = lead.emit;
         if (lead.start) begin
            st_expected = lead.len;
            st_seen     = LEN_ONE;
            st_acc      = lead.bits;
         end
      end
      c_v = final_byte && (st_expected != LEN_NONE) && (st_seen < st_expected);
      if (c_v) begin
         expected_in = LEN_NONE;
         seen_in     = LEN_NONE;
         acc_in      = ZERO_BITS;
      end else begin
         expected_in = st_expected;
         seen_in     = st_seen;
         acc_in      = st_acc;
      end
   end

   assign r0_v = a_v || c_v;
   assign r1_v = a_v && (b_v || c_v);

   always_comb begin
      q_entry.two  = r1_v;
      q_entry.cp0  = a_v ? a_cp : REPLACEMENT_CP;
      q_entry.rep0 = a_v ? a_rep : 1'b1;
      q_entry.cp1  = b_v ? b_cp : REPLACEMENT_CP;
      q_entry.rep1 = b_v ? b_rep : 1'b1;
   end

   assign q_push = accept && r0_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= LEN_NONE;
         seen_ff     <= LEN_NONE;
         acc_ff      <= ZERO_BITS;
      end else if (accept) begin
         expected_ff <= expected_in;
         seen_ff     <= seen_in;
         acc_ff      <= acc_in;
      end
   end

endmodule

[rtl/core/u2c_queue.sv]
// Small register queue of per-byte result entries between front and back ends.
module u2c_queue
   import u2c_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      q_push,
   input  entry_type q_entry_in,
   output logic      q_full,
   input  logic      q_pop,
   output entry_type q_entry_out,
   output logic      q_empty
);

   entry_type                  mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0] count_ff, count_in;
   logic                       do_push, do_pop;

   assign q_full      = (count_ff == QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign q_empty     = (count_ff == '0);
   assign do_push     = q_push && !q_full;
   assign do_pop      = q_pop && !q_empty;
   assign q_entry_out = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         mem_ff[wr_ptr_ff] <= q_entry_in;
   end

endmodule

[rtl/core/u2c_back.sv]
// Back end: unpacks queue entries into single results behind an output register.
module u2c_back
   import u2c_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  entry_type           q_entry,
   output logic                q_pop,
   output logic                empty,
   input  logic                pop,
   output logic [CP_WIDTH-1:0] rsp_code_point,
   output logic                rsp_replaced,
   output logic                rsp_last_of_run
);

   logic                out_valid_ff, out_valid_in;
   logic [CP_WIDTH-1:0] out_cp_ff, out_cp_in;
   logic                out_rep_ff, out_rep_in;
   logic                out_last_ff, out_last_in;
   logic                hold_valid_ff, hold_valid_in;
   logic [CP_WIDTH-1:0] hold_cp_ff, hold_cp_in;
   logic                hold_rep_ff, hold_rep_in;
   logic                take;

   assign take = !out_valid_ff || pop;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_cp_in     = out_cp_ff;
      out_rep_in    = out_rep_ff;
      out_last_in   = out_last_ff;
      hold_valid_in = hold_valid_ff;
      hold_cp_in    = hold_cp_ff;
      hold_rep_in   = hold_rep_ff;
      q_pop         = 1'b0;
      if (take) begin
         priority if (hold_valid_ff) begin
            out_valid_in  = 1'b1;
            out_cp_in     = hold_cp_ff;
            out_rep_in    = hold_rep_ff;
            out_last_in   = 1'b1;
            hold_valid_in = 1'b0;
         end else if (!q_empty) begin
            q_pop         = 1'b1;
            out_valid_in  = 1'b1;
            out_cp_in     = q_entry.cp0;
            out_rep_in    = q_entry.rep0;
            out_last_in   = !q_entry.two;
            hold_valid_in = q_entry.two;
            hold_cp_in    = q_entry.cp1;
            hold_rep_in   = q_entry.rep1;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_cp_ff   <= out_cp_in;
      out_rep_ff  <= out_rep_in;
      out_last_ff <= out_last_in;
      hold_cp_ff  <= hold_cp_in;
      hold_rep_ff <= hold_rep_in;
   end

   assign empty           = !out_valid_ff;
   assign rsp_code_point  = out_cp_ff;
   assign rsp_replaced    = out_rep_ff;
   assign rsp_last_of_run = out_last_ff;

endmodule

[rtl/core/utf8_to_codepoint_decoder_core.sv]
// Top level of the UTF-8 to code point decoder with error replacement.
// The decoder takes one byte per request and can accept a byte in every cycle in which
// the queue is not full; its sequence state is updated in the same cycle the byte is
// accepted. Each byte gives zero, one or two code points, packed as one entry into a
// four-entry queue; the output register delivers one code point per cycle while pop
// is held, the two results of a byte one after the other. The last code point caused
// by a byte carries rsp_last_of_run. Malformed input gives U+FFFD with rsp_replaced set.
module utf8_to_codepoint_decoder_core
   import u2c_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [BYTE_WIDTH-1:0] req_text_byte,
   input  logic                  req_final_byte,
   output logic                  empty,
   input  logic                  pop,
   output logic [CP_WIDTH-1:0]   rsp_code_point,
   output logic                  rsp_replaced,
   output logic                  rsp_last_of_run
);

   logic      accept;
   logic      q_push, q_full, q_pop, q_empty;
   entry_type q_entry_in, q_entry_out;

   assign full   = q_full;
   assign accept = push && !q_full;

   u2c_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .text_byte  (req_text_byte),
      .final_byte (req_final_byte),
      .q_push     (q_push),
      .q_entry    (q_entry_in)
   );

   u2c_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .q_push      (q_push),
      .q_entry_in  (q_entry_in),
      .q_full      (q_full),
      .q_pop       (q_pop),
      .q_entry_out (q_entry_out),
      .q_empty     (q_empty)
   );

   u2c_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_entry         (q_entry_out),
      .q_pop           (q_pop),
      .empty           (empty),
      .pop             (pop),
      .rsp_code_point  (rsp_code_point),
      .rsp_replaced    (rsp_replaced),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // A replacement result always carries U+FFFD.
   a_replaced_value: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_replaced |-> rsp_code_point == REPLACEMENT_CP)
      else $error("replaced result without U+FFFD");

   // A decoded result is a Unicode scalar value.
   a_scalar_value: assert property (@(posedge clock) disable iff (reset)
      !empty && !rsp_replaced |-> rsp_code_point <= MAX_CP &&
         (rsp_code_point < SURROGATE_FIRST || rsp_code_point > SURROGATE_LAST))
      else $error("decoded result outside the scalar range");

   // The first of two results from one byte is always a replacement.
   a_first_of_two: assert property (@(posedge clock) disable iff (reset)
      !empty && !rsp_last_of_run |-> rsp_replaced)
      else $error("first of two results is not a replacement");

   // The second result of a byte follows its first without a gap.
   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      !empty && !rsp_last_of_run && pop |=> !empty)
      else $error("second result of a byte not presented next");

endmodule

[tb/tb_utf8_to_codepoint_decoder_core.sv]
// Self-checking testbench for the UTF-8 to code point decoder with queue-style handshakes.
module tb_utf8_to_codepoint_decoder_core;
   import u2c_pkg::*;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] text;
      logic                  fin;
   } text_item_type;

   typedef struct packed {
      logic [CP_WIDTH-1:0] cp;
      logic                rep;
      logic                last;
   } code_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  full;
   logic [BYTE_WIDTH-1:0] req_text_byte = '0;
   logic                  req_final_byte = 1'b0;
   logic                  empty;
   logic                  pop = 1'b0;
   logic [CP_WIDTH-1:0]   rsp_code_point;
   logic                  rsp_replaced;
   logic                  rsp_last_of_run;

   text_item_type   text_bytes[$];
   code_result_type expected_points[$];
   code_result_type step_points[$];

   logic [LEN_WIDTH-1:0] seq_len = LEN_NONE;
   logic [LEN_WIDTH-1:0] seq_cnt = LEN_NONE;
   logic [CP_WIDTH-1:0]  code_acc = ZERO_BITS;

   int bytes_sent     = 0;
   int points_checked = 0;
   int replacements   = 0;
   int failures       = 0;

   utf8_to_codepoint_decoder_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_text_byte   (req_text_byte),
      .req_final_byte  (req_final_byte),
      .empty           (empty),
      .pop             (pop),
      .rsp_code_point  (rsp_code_point),
      .rsp_replaced    (rsp_replaced),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic emit_point(input logic [CP_WIDTH-1:0] cp, input logic rep);
      code_result_type r;
      r.cp   = cp;
      r.rep  = rep;
      r.last = 1'b0;
      step_points.push_back(r);
   endtask

   task automatic clear_sequence();
      seq_len  = LEN_NONE;
      seq_cnt  = LEN_NONE;
      code_acc = ZERO_BITS;
   endtask

   task automatic open_sequence(input logic [LEN_WIDTH-1:0] len,
                                input logic [CP_WIDTH-1:0] bits);
      seq_len  = len;
      seq_cnt  = LEN_ONE;
      code_acc = bits;
   endtask

   task automatic decode_fresh(input logic [BYTE_WIDTH-1:0] c);
      if (c <= ASCII_LAST)
         emit_point({13'd0, c}, 1'b0);
      else if (c >= NEVER_VALID_LOW || c == NEVER_VALID_C1)
         emit_point(REPLACEMENT_CP, 1'b1);
      else if (c >= LEAD_FOUR_FIRST)
         open_sequence(LEN_FOUR, {18'd0, c[2:0]});
      else if (c >= LEAD_THREE_FIRST)
         open_sequence(LEN_THREE, {17'd0, c[3:0]});
      else if (c >= LEAD_TWO_FIRST)
         open_sequence(LEN_TWO, {16'd0, c[4:0]});
      else
         emit_point(REPLACEMENT_CP, 1'b1);
   endtask

   function automatic logic second_byte_rejected(input logic [BYTE_WIDTH-1:0] c);
      if (seq_cnt != LEN_ONE)
         return 1'b0;
      if (seq_len == LEN_FOUR && code_acc == F4_LEAD_BITS && c >= F0_CONT_MIN)
         return 1'b1;
      if (code_acc == ZERO_BITS) begin
         if (seq_len == LEN_THREE && c < E0_CONT_MIN)
            return 1'b1;
         if (seq_len == LEN_FOUR && c < F0_CONT_MIN)
            return 1'b1;
         if (seq_len == LEN_TWO && c != C0_CONT_ONLY)
            return 1'b1;
      end
      return 1'b0;
   endfunction

   // Advances the decoder state by one byte and queues the code points it yields.
   task automatic predict_code_points(input logic [BYTE_WIDTH-1:0] c, input logic fin);
      logic busy;
      busy = seq_len != LEN_NONE && seq_cnt < seq_len;
      step_points.delete();
      if (!busy) begin
         clear_sequence();
         decode_fresh(c);
      end else if (c[7:6] == CONT_TAG && !second_byte_rejected(c)) begin
         code_acc = {code_acc[CP_WIDTH-7:0], c[5:0]};
         seq_cnt  = seq_cnt + LEN_ONE;
         if (seq_cnt == seq_len) begin
            if (seq_len == LEN_THREE && code_acc >= SURROGATE_FIRST &&
                code_acc <= SURROGATE_LAST)
               emit_point(REPLACEMENT_CP, 1'b1);
            else
               emit_point(code_acc, 1'b0);
            clear_sequence();
         end
      end else begin
         emit_point(REPLACEMENT_CP, 1'b1);
         clear_sequence();
         decode_fresh(c);
      end
      if (fin && seq_len != LEN_NONE && seq_cnt < seq_len) begin
         emit_point(REPLACEMENT_CP, 1'b1);
         clear_sequence();
      end
      if (step_points.size() > 0)
         step_points[step_points.size()-1].last = 1'b1;
      foreach (step_points[i])
         expected_points.push_back(step_points[i]);
   endtask

   task automatic add_text_byte(input logic [BYTE_WIDTH-1:0] b, input logic fin);
      text_item_type t;
      t.text = b;
      t.fin  = fin;
      text_bytes.push_back(t);
   endtask

   // Encodes a scalar in the given length and queues the first keep bytes of it.
   task automatic add_encoded(input logic [CP_WIDTH-1:0] cp, input int len, input int keep,
                              input logic fin_at_end);
      logic [BYTE_WIDTH-1:0] enc[4];
      case (len)
         1: enc[0] = {1'b0, cp[6:0]};
         2: begin
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {CONT_TAG, cp[5:0]};
         end
         3: begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {CONT_TAG, cp[11:6]};
            enc[2] = {CONT_TAG, cp[5:0]};
         end
         default: begin
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {CONT_TAG, cp[17:12]};
            enc[2] = {CONT_TAG, cp[11:6]};
            enc[3] = {CONT_TAG, cp[5:0]};
         end
      endcase
      for (int i = 0; i < keep; i++)
         add_text_byte(enc[i], (i == keep - 1) ? fin_at_end : ($urandom_range(0, 19) == 0));
   endtask

   task automatic add_random_text();
      int kind;
      int len;
      int n;
      logic [CP_WIDTH-1:0] cp;
      kind = int'($urandom_range(0, 99));
      len  = int'($urandom_range(1, 4));
      case (len)
         1: cp = CP_WIDTH'($urandom_range(0, 'h7F));
         2: cp = CP_WIDTH'($urandom_range('h80, 'h7FF));
         3: cp = ($urandom_range(0, 5) == 0) ? CP_WIDTH'($urandom_range('hD700, 'hE0FF))
                                             : CP_WIDTH'($urandom_range('h800, 'hFFFF));
         default: cp = CP_WIDTH'($urandom_range('h10000, 'h10FFFF));
      endcase
      if (kind < 62) begin
         add_encoded(cp, len, len, $urandom_range(0, 9) == 0);
      end else if (kind < 72) begin
         add_encoded(cp, len, int'($urandom_range(1, len)), 1'($urandom_range(0, 1)));
      end else if (kind < 84) begin
         // Boundary leads followed by arbitrary continuation bytes.
         case ($urandom_range(0, 3))
            0: add_text_byte(LEAD_TWO_FIRST, 1'b0);
            1: add_text_byte(LEAD_THREE_FIRST, 1'b0);
            2: add_text_byte(LEAD_FOUR_FIRST, 1'b0);
            default: add_text_byte(8'hF4, 1'b0);
         endcase
         n = int'($urandom_range(1, 3));
         for (int i = 0; i < n; i++)
            add_text_byte(BYTE_WIDTH'($urandom_range('h80, 'hBF)),
                          $urandom_range(0, 9) == 0);
      end else begin
         add_text_byte(BYTE_WIDTH'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            predict_code_points(req_text_byte, req_final_byte);
            bytes_sent <= bytes_sent + 1;
         end
         if (!push || !full) begin
            if (text_bytes.size() > 0 &&
                ((bytes_sent >= 150 && bytes_sent < 250) || $urandom_range(0, 99) >= 29)) begin
               push           <= 1'b1;
               req_text_byte  <= text_bytes[0].text;
               req_final_byte <= text_bytes[0].fin;
               void'(text_bytes.pop_front());
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      code_result_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_points.size() == 0) begin
               failures = failures + 1;
               if (failures <= 10)
                  $display("Unexpected code point %06h replaced %0b last %0b",
                           rsp_code_point, rsp_replaced, rsp_last_of_run);
            end else begin
               want = expected_points.pop_front();
               points_checked = points_checked + 1;
               if (want.rep)
                  replacements = replacements + 1;
               if (rsp_code_point !== want.cp || rsp_replaced !== want.rep ||
                   rsp_last_of_run !== want.last) begin
                  failures = failures + 1;
                  if (failures <= 10)
                     $display("Mismatch on code point %0d: expected %06h/%0b/%0b, got %06h/%0b/%0b",
                              points_checked, want.cp, want.rep, want.last,
                              rsp_code_point, rsp_replaced, rsp_last_of_run);
               end
            end
         end
         pop <= (points_checked >= 200 && points_checked < 300) ||
                ($urandom_range(0, 99) >= 29);
      end
   end

   initial begin
      // Directed bytes: extremes, every lead class and malformed cases.
      add_text_byte(8'h00, 1'b0);
      add_text_byte(8'h7F, 1'b1);
      add_text_byte(8'hC0, 1'b0);
      add_text_byte(8'h80, 1'b0);
      add_text_byte(8'hC0, 1'b0);
      add_text_byte(8'h81, 1'b0);
      add_text_byte(8'hC1, 1'b0);
      add_text_byte(8'hFF, 1'b0);
      add_text_byte(8'h80, 1'b0);
      add_text_byte(8'hC2, 1'b0);
      add_text_byte(8'hA9, 1'b0);
      add_text_byte(8'hE0, 1'b0);
      add_text_byte(8'h9F, 1'b0);
      add_text_byte(8'hED, 1'b0);
      add_text_byte(8'hA0, 1'b0);
      add_text_byte(8'h80, 1'b0);
      add_encoded(21'h10FFFF, 4, 4, 1'b0);
      add_text_byte(8'hF4, 1'b0);
      add_text_byte(8'h90, 1'b0);
      add_text_byte(8'hE2, 1'b0);
      add_text_byte(8'h41, 1'b0);
      add_text_byte(8'hC3, 1'b1);
      add_text_byte(8'hF0, 1'b0);
      add_text_byte(8'hC3, 1'b0);
      add_text_byte(8'hBF, 1'b1);
      while (text_bytes.size() < 400)
         add_random_text();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (text_bytes.size() != 0 || push)
         @(posedge clock);
      while (expected_points.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      failures = failures + expected_points.size();

      $display("Fed %0d UTF-8 bytes and checked %0d code points, %0d of them replacements.",
               bytes_sent, points_checked, replacements);
      if (failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("Decoder run timed out.");
      $display("Some tests failed");
      $finish;
   end

endmodule

[files.f]
rtl/core/u2c_pkg.sv
rtl/core/u2c_front.sv
rtl/core/u2c_queue.sv
rtl/core/u2c_back.sv
rtl/core/utf8_to_codepoint_decoder_core.sv
tb/tb_utf8_to_codepoint_decoder_core.sv
